// ===== rtl/hpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hpfm_pkg: shared definitions for the hysteresis period frequency meter
// Constants for the timebase and scaling, and the divider request and
// response types.
// ----------------------------------------------------------------------------
package hpfm_pkg;

  localparam int unsigned TICK_RATE_HZ = 100000;
  localparam int unsigned TS_W         = 32;
  localparam int unsigned SMP_W        = 8;
  localparam int unsigned KHZ_W        = 7;
  localparam int unsigned KHZ_DIVISOR  = 1000;
  localparam int unsigned FREQ_MAX_KHZ = 100;

  // Dividend width of the divider: wide enough for the tick rate.
  localparam int unsigned DVD_W = $clog2(TICK_RATE_HZ + 1);
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  // Reciprocal of the kHz divisor, exact for every quotient of DVD_W bits.
  localparam int unsigned     KHZ_SHIFT = DVD_W + 10;
  localparam int unsigned     KHZ_RCP_W = KHZ_SHIFT - 9;
  localparam longint unsigned KHZ_RCP   =
    ((64'd1 << KHZ_SHIFT) + 64'(KHZ_DIVISOR) - 64'd1) / 64'(KHZ_DIVISOR);
  localparam int unsigned     PROD_W    = DVD_W + KHZ_RCP_W;

  // Configuration register indexes.
  localparam logic CFG_THR_HIGH = 1'b0;
  localparam logic CFG_THR_LOW  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [TS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== rtl/hpfm_div.sv =====
// ----------------------------------------------------------------------------
// hpfm_div: iterative divider
// Restoring division, one quotient bit per cycle for the DVD_W dividend bits. A start
// request loads the operands; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module hpfm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpfm_pkg::div_req_t  req_i,
  output hpfm_pkg::div_rsp_t  rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [hpfm_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [hpfm_pkg::DVD_W-1:0]    dvd_q, dvd_d;
  logic [hpfm_pkg::TS_W-1:0]     rem_q, rem_d;
  logic [hpfm_pkg::TS_W-1:0]     dsr_q, dsr_d;
  logic [hpfm_pkg::TS_W:0]       rem_sh;
  logic [hpfm_pkg::TS_W:0]       rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, dvd_q[hpfm_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = hpfm_pkg::CNT_W'(hpfm_pkg::DVD_W);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[hpfm_pkg::DVD_W-2:0], ge};
      rem_d = ge ? rem_sub[hpfm_pkg::TS_W-1:0] : rem_sh[hpfm_pkg::TS_W-1:0];
      cnt_d = cnt_q - hpfm_pkg::CNT_W'(1);
      if (cnt_q == hpfm_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== rtl/hysteresis_period_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// hysteresis_period_frequency_meter: edge period to frequency converter
// A result that needs the divider goes through a divider pass, the kHz scaling into
// the result register and the output register; a zero period skips the divider and
// its result goes from the result register to the output register.
// Throughput: one item per cycle when no result is due; while a result is being
// worked out or waits for a stalled output, no new item is accepted.
// Reset: thresholds return to 192 and 64, the comparator is disarmed and the
// stored edge time is cleared; the output register is emptied.
// ----------------------------------------------------------------------------
module hysteresis_period_frequency_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample [7:0], timestamp [39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // frequency_khz [6:0], zero [7]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [hpfm_pkg::SMP_W-1:0]      thr_high_q, thr_low_q;
  logic                            armed_q, armed_d;
  logic [hpfm_pkg::TS_W-1:0]       last_q, last_d;
  logic [hpfm_pkg::KHZ_W-1:0]      res_q, res_d;
  logic                            ovalid_q, ovalid_d;
  logic [hpfm_pkg::KHZ_W-1:0]      odata_q, odata_d;
  hpfm_pkg::div_req_t              div_req;
  hpfm_pkg::div_rsp_t              div_rsp;
  logic                            accept;
  logic [hpfm_pkg::SMP_W-1:0]      sample;
  logic [hpfm_pkg::TS_W-1:0]       stamp;
  logic [hpfm_pkg::TS_W-1:0]       period;
  logic                            out_free;
  logic [hpfm_pkg::PROD_W-1:0]     khz_prod;
  logic [hpfm_pkg::DVD_W-1:0]      khz_val;

  assign sample   = s_axis_tdata[hpfm_pkg::SMP_W-1:0];
  assign stamp    = s_axis_tdata[hpfm_pkg::SMP_W+hpfm_pkg::TS_W-1:hpfm_pkg::SMP_W];
  assign period   = stamp - last_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign khz_prod = hpfm_pkg::PROD_W'(div_rsp.quotient) *
                    hpfm_pkg::PROD_W'(hpfm_pkg::KHZ_RCP);
  assign khz_val  = hpfm_pkg::DVD_W'(khz_prod >> hpfm_pkg::KHZ_SHIFT);

  hpfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    armed_d  = armed_q;
    last_d   = last_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    div_req.start    = 1'b0;
    div_req.dividend = hpfm_pkg::DVD_W'(hpfm_pkg::TICK_RATE_HZ);
    div_req.divisor  = period;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!armed_q) begin
            if (sample >= thr_high_q) begin
              armed_d = 1'b1;
              last_d  = stamp;
              if (last_q != '0) begin
                if (period == '0) begin
                  res_d   = hpfm_pkg::KHZ_W'(hpfm_pkg::FREQ_MAX_KHZ);
                  state_d = ST_OUT;
                end else begin
                  div_req.start = 1'b1;
                  state_d       = ST_DIV;
                end
              end
            end
          end else if (sample <= thr_low_q) begin
            armed_d = 1'b0;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (khz_val > hpfm_pkg::DVD_W'(hpfm_pkg::FREQ_MAX_KHZ)) begin
            res_d = hpfm_pkg::KHZ_W'(hpfm_pkg::FREQ_MAX_KHZ);
          end else begin
            res_d = khz_val[hpfm_pkg::KHZ_W-1:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      armed_q    <= 1'b0;
      last_q     <= '0;
      ovalid_q   <= 1'b0;
      thr_high_q <= 8'd192;
      thr_low_q  <= 8'd64;
    end else begin
      state_q  <= state_d;
      armed_q  <= armed_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hpfm_pkg::CFG_THR_HIGH: thr_high_q <= cfg_wdata_i;
          hpfm_pkg::CFG_THR_LOW:  thr_low_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, odata_q};

endmodule

// ===== dv/hpfm_freq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpfm_freq_checker: result checker for the hysteresis period frequency meter
// Watches the sample, result and register write ports. It keeps its own copy
// of the thresholds, the comparator state and the last edge time, and works
// out the frequency in kHz that each arming edge should produce. Every result
// item is compared with the oldest outstanding frequency.
// ----------------------------------------------------------------------------
module hpfm_freq_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [39:0]             s_axis_tdata,   // sample [7:0], timestamp [39:8]
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [7:0]              m_axis_tdata,   // frequency_khz [6:0], zero [7]
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [7:0]              cfg_wdata_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             pending_o
);

  localparam logic [hpfm_pkg::SMP_W-1:0] THR_HIGH_RESET = 8'd192;
  localparam logic [hpfm_pkg::SMP_W-1:0] THR_LOW_RESET  = 8'd64;
  localparam int unsigned                REPORT_LIMIT   = 10;

  logic [hpfm_pkg::SMP_W-1:0] thr_high;
  logic [hpfm_pkg::SMP_W-1:0] thr_low;
  logic                       armed;
  logic [hpfm_pkg::TS_W-1:0]  last_edge;
  logic [hpfm_pkg::KHZ_W-1:0] khz_expected_q[$];

  function automatic logic [hpfm_pkg::KHZ_W-1:0] khz_from_period(
    input logic [hpfm_pkg::TS_W-1:0] period
  );
    logic [hpfm_pkg::TS_W-1:0] per_second;
    logic [hpfm_pkg::TS_W-1:0] khz;
    if (period == '0) begin
      return hpfm_pkg::KHZ_W'(hpfm_pkg::FREQ_MAX_KHZ);
    end
    per_second = hpfm_pkg::TS_W'(hpfm_pkg::TICK_RATE_HZ) / period;
    khz        = per_second / hpfm_pkg::TS_W'(hpfm_pkg::KHZ_DIVISOR);
    if (khz > hpfm_pkg::TS_W'(hpfm_pkg::FREQ_MAX_KHZ)) begin
      khz = hpfm_pkg::TS_W'(hpfm_pkg::FREQ_MAX_KHZ);
    end
    return khz[hpfm_pkg::KHZ_W-1:0];
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i) begin
    logic [hpfm_pkg::SMP_W-1:0] level;
    logic [hpfm_pkg::TS_W-1:0]  now;
    logic [hpfm_pkg::KHZ_W-1:0] want;
    if (!rst_ni) begin
      thr_high  = THR_HIGH_RESET;
      thr_low   = THR_LOW_RESET;
      armed     = 1'b0;
      last_edge = '0;
      khz_expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        level = s_axis_tdata[hpfm_pkg::SMP_W-1:0];
        now   = s_axis_tdata[hpfm_pkg::SMP_W +: hpfm_pkg::TS_W];
        if (!armed) begin
          if (level >= thr_high) begin
            armed = 1'b1;
            if (last_edge != '0) begin
              khz_expected_q.push_back(khz_from_period(now - last_edge));
            end
            last_edge = now;
          end
        end else if (level <= thr_low) begin
          armed = 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (khz_expected_q.size() == 0) begin
          note_mismatch($sformatf("unexpected item, frequency_khz %0d",
                                  m_axis_tdata[hpfm_pkg::KHZ_W-1:0]));
        end else begin
          want = khz_expected_q.pop_front();
          if (m_axis_tdata[hpfm_pkg::KHZ_W-1:0] !== want) begin
            note_mismatch($sformatf("frequency_khz expected %0d, actual %0d",
                                    want, m_axis_tdata[hpfm_pkg::KHZ_W-1:0]));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == hpfm_pkg::CFG_THR_HIGH) begin
          thr_high = cfg_wdata_i;
        end else if (cfg_idx_i == hpfm_pkg::CFG_THR_LOW) begin
          thr_low = cfg_wdata_i;
        end
      end
    end
    pending_o = unsigned'(khz_expected_q.size());
  end

endmodule

// ===== dv/hysteresis_period_frequency_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysteresis_period_frequency_meter_tb: testbench top for the frequency meter
// Drives timestamped samples through the stream input, with threshold
// settings changed between phases while the block is idle. A directed part
// covers the edge cases of the comparator and the period arithmetic; random
// phases follow with random crossings, short periods and wrapping time.
// Both sides idle in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module hysteresis_period_frequency_meter_tb;

  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES    = 2 * hpfm_pkg::DVD_W + 10;
  localparam int unsigned RANDOM_PHASES   = 5;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // sample [7:0], timestamp [39:8]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // frequency_khz [6:0], zero [7]
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  int unsigned               mismatch_count;
  int unsigned               pending;
  int unsigned               quiet_cycles;
  bit                        idle_en;
  logic [hpfm_pkg::TS_W-1:0] stamp;
  logic [7:0]                cur_high;
  logic [7:0]                cur_low;

  always #5 clk_i = ~clk_i;

  hysteresis_period_frequency_meter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  hpfm_freq_checker u_freq_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  task automatic drive_sample(input logic [hpfm_pkg::SMP_W-1:0] level,
                              input logic [hpfm_pkg::TS_W-1:0] ts);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ts, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_thresholds(input logic [7:0] high, input logic [7:0] low);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= hpfm_pkg::CFG_THR_HIGH;
    cfg_wdata_i <= high;
    @(negedge clk_i);
    cfg_idx_i   <= hpfm_pkg::CFG_THR_LOW;
    cfg_wdata_i <= low;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    cur_high = high;
    cur_low  = low;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic drive_random_sample();
    logic [hpfm_pkg::SMP_W-1:0] level;
    int unsigned                pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      level = hpfm_pkg::SMP_W'($urandom_range(cur_high, 255));
    end else if (pick < 8) begin
      level = hpfm_pkg::SMP_W'($urandom_range(0, cur_low));
    end else begin
      level = hpfm_pkg::SMP_W'($urandom);
    end
    pick = $urandom_range(0, 19);
    case (pick)
      0: stamp = $urandom;
      1: stamp = '0;
      2: stamp = stamp - $urandom_range(0, 8);
      3: stamp = 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: stamp = stamp + $urandom_range(0, 25);
    endcase
    drive_sample(level, stamp);
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  initial begin
    idle_en       = 1'b1;
    stamp         = '0;
    cur_high      = 8'd192;
    cur_low       = 8'd64;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = hpfm_pkg::CFG_THR_HIGH;
    cfg_wdata_i   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // An edge at time zero arms the comparator but leaves the stored edge time as if no edge had been seen.
    drive_sample(8'd255, 32'd0);
    drive_sample(8'd0,   32'd5);
    drive_sample(8'd200, 32'd10);
    drive_sample(8'd64,  32'd11);
    drive_sample(8'd192, 32'd11);
    drive_sample(8'd65,  32'd12);
    drive_sample(8'd255, 32'd13);
    drive_sample(8'd0,   32'd13);
    drive_sample(8'd191, 32'd14);
    drive_sample(8'd192, 32'd11);
    drive_sample(8'd0,   32'hFFFF_FFFF);
    drive_sample(8'd255, 32'd111);
    drive_sample(8'd0,   32'd150);
    drive_sample(8'd255, 32'd212);
    drive_sample(8'd0,   32'd213);
    drive_sample(8'd255, 32'd219);
    drive_sample(8'd0,   32'd220);
    drive_sample(8'd255, 32'hFFFF_FFF0);
    drive_sample(8'd0,   32'hFFFF_FFF8);
    drive_sample(8'd255, 32'h0000_0010);
    settle();

    // Crossed thresholds: every sample toggles the comparator.
    write_thresholds(8'd0, 8'd255);
    drive_sample(8'd0,   32'd20);
    drive_sample(8'd255, 32'd21);
    drive_sample(8'd0,   32'd23);
    settle();

    write_thresholds(8'd255, 8'd0);
    drive_sample(8'd1,   32'd30);
    drive_sample(8'd0,   32'd31);
    drive_sample(8'd254, 32'd32);
    drive_sample(8'd255, 32'd40);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_thresholds(8'd192, 8'd64);
        1: write_thresholds(8'($urandom_range(128, 255)), 8'($urandom_range(0, 127)));
        2: write_thresholds(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
        3: write_thresholds(8'd255, 8'd0);
        default: write_thresholds(8'($urandom_range(100, 255)), 8'($urandom_range(0, 150)));
      endcase
      idle_en = (phase != RANDOM_PHASES - 1);
      repeat (ITEMS_PER_PHASE) drive_random_sample();
      settle();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hpfm_pkg.sv
rtl/hpfm_div.sv
rtl/hysteresis_period_frequency_meter.sv
dv/hpfm_freq_checker.sv
dv/hysteresis_period_frequency_meter_tb.sv
